/* rtl/core/ebml_pkg.sv */
// Package for the escaped byte stream memory loader.
// Holds the command byte codes, LED codes, mode type and the result struct.
// No dependencies; compile first.
package ebml_pkg;

  // Width of the load address counter (8 to 32)
  localparam int AddrWidth = 32;

  // Command bytes
  localparam logic [7:0] ByteEscape = 8'h7e;
  localparam logic [7:0] ByteLoad   = 8'h01;
  localparam logic [7:0] ByteExit   = 8'h00;

  // Status LED codes
  localparam logic [7:0] LedReset     = 8'haa;
  localparam logic [7:0] LedExit      = 8'hff;
  localparam logic [7:0] LedBusy      = 8'h07;
  localparam logic [7:0] LedLoadStart = 8'h01;
  localparam logic [7:0] LedLoadReady = 8'h02;

  // Number of raw address bytes after a load command
  localparam logic [2:0] AddrBytes = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_HALT = 2'd2
  } mode_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        exit_now;
    logic [7:0]  status_leds;
  } result_t;

endpackage

/* rtl/core/ebml_if.sv */
// Handshake channels of the loader: received bytes in, write commands out.
// Depends on nothing but the language; compile after ebml_pkg.
interface ebml_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ebml_cmd_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic        exit_now;
  logic [7:0]  status_leds;

  modport source (
    output valid, output write_valid, output write_address, output write_data,
    output exit_now, output status_leds, input ready
  );
  modport sink (
    input valid, input write_valid, input write_address, input write_data,
    input exit_now, input status_leds, output ready
  );
endinterface

/* rtl/core/ebml_in_stage.sv */
// Input register of the loader: holds one received byte until the decoder takes it.
// Depends on ebml_if.
module ebml_in_stage (
  input  logic         clk,
  input  logic         rst,
  ebml_byte_if.sink    rx,
  input  logic         take,
  output logic         full,
  output logic [7:0]   data
);

  // Accept when empty or when the held item leaves this cycle
  assign rx.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

/* rtl/core/ebml_decode.sv */
// Loader decoder: mode, escape, address collection and LED state, plus
// the single-pass result for one byte. Depends on ebml_pkg.
module ebml_decode import ebml_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  mode_t                mode, mode_next;
  logic                 escape_pending, escape_pending_next;
  logic [2:0]           bytes_left, bytes_left_next;
  logic [AddrWidth-1:0] current_address, current_address_next;
  logic [7:0]           led_value, led_value_next;

  logic [4:0]  addr_shift;
  logic [31:0] addr_merged;

  // Place of the incoming address byte, little-endian
  assign addr_shift  = {2'(AddrBytes - bytes_left), 3'b000};
  assign addr_merged = 32'(current_address) | (32'(rx_byte) << addr_shift);

  // Next state and result for one byte
  always_comb begin
    mode_next            = mode;
    escape_pending_next  = escape_pending;
    bytes_left_next      = bytes_left;
    current_address_next = current_address;
    led_value_next       = led_value;
    res                  = '0;

    if (fire && mode != MODE_HALT) begin
      if (bytes_left inside {[3'd1:3'd4]}) begin
        // Raw address byte
        current_address_next = addr_merged[AddrWidth-1:0];
        bytes_left_next      = bytes_left - 3'd1;
        if (bytes_left == 3'd1) begin
          led_value_next = LedLoadReady;
          mode_next      = MODE_LOAD;
        end
      end else begin
        bytes_left_next = 3'd0;
        if (escape_pending) begin
          // Escaped byte is plain data
          escape_pending_next = 1'b0;
          if (mode == MODE_LOAD) begin
            res.write_valid      = 1'b1;
            res.write_address    = 32'(current_address);
            res.write_data       = rx_byte;
            led_value_next       = rx_byte;
            current_address_next = current_address + AddrWidth'(1);
          end
        end else begin
          led_value_next = LedBusy;
          case (rx_byte)
            ByteEscape: begin
              escape_pending_next = 1'b1;
            end
            ByteLoad: begin
              current_address_next = '0;
              led_value_next       = LedLoadStart;
              bytes_left_next      = AddrBytes;
            end
            ByteExit: begin
              led_value_next = LedExit;
              mode_next      = MODE_HALT;
              res.exit_now   = 1'b1;
            end
            default: begin
              if (mode == MODE_LOAD) begin
                res.write_valid      = 1'b1;
                res.write_address    = 32'(current_address);
                res.write_data       = rx_byte;
                led_value_next       = rx_byte;
                current_address_next = current_address + AddrWidth'(1);
              end
            end
          endcase
        end
      end
    end
    res.status_leds = led_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      escape_pending  <= 1'b0;
      bytes_left      <= 3'd0;
      current_address <= '0;
      led_value       <= LedReset;
    end else begin
      mode            <= mode_next;
      escape_pending  <= escape_pending_next;
      bytes_left      <= bytes_left_next;
      current_address <= current_address_next;
      led_value       <= led_value_next;
    end
  end

endmodule

/* rtl/core/ebml_out_stage.sv */
// Result register of the loader: holds one write command until taken.
// Depends on ebml_pkg and ebml_if.
module ebml_out_stage import ebml_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        space,
  ebml_cmd_if.source  wr
);

  result_t held;

  // Free when empty or when the held item is taken this cycle
  assign space = !wr.valid || wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr.valid <= 1'b0;
    end else if (load) begin
      wr.valid <= 1'b1;
    end else if (wr.ready) begin
      wr.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign wr.write_valid   = held.write_valid;
  assign wr.write_address = held.write_address;
  assign wr.write_data    = held.write_data;
  assign wr.exit_now      = held.exit_now;
  assign wr.status_leds   = held.status_leds;

endmodule

/* rtl/core/escaped_byte_stream_memory_loader.sv */
// Escaped byte stream memory loader: one write command item per received byte.
// Path from byte accept to command out: input register, decoder, result register.
// Throughput: one byte per cycle while wr.ready keeps the result register free.
// Reset (rst, synchronous): idle mode, no escape, address 0, LEDs 0xAA,
// both stage registers empty.
module escaped_byte_stream_memory_loader import ebml_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ebml_byte_if.sink   rx,
  ebml_cmd_if.source  wr
);

  logic       s1_full;
  logic [7:0] s1_data;
  logic       s1_take;
  logic       out_space;
  result_t    res;

  // Move the held byte through the decoder when the result register has room
  assign s1_take = s1_full && out_space;

  ebml_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (s1_take),
    .full (s1_full),
    .data (s1_data)
  );

  ebml_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .fire    (s1_take),
    .rx_byte (s1_data),
    .res     (res)
  );

  ebml_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (s1_take),
    .res   (res),
    .space (out_space),
    .wr    (wr)
  );

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready && s1_full |-> s1_take)
    else $error("input byte overwritten");

  a_write_led: assert property (@(posedge clk) disable iff (rst)
    s1_take && res.write_valid |-> res.status_leds == res.write_data && !res.exit_now)
    else $error("LEDs do not follow written byte");

  a_exit_led: assert property (@(posedge clk) disable iff (rst)
    s1_take && res.exit_now |-> res.status_leds == LedExit)
    else $error("exit without exit LED code");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    s1_take && !res.write_valid |-> res.write_address == 32'd0 && res.write_data == 8'd0)
    else $error("non-write result carries address or data");
`endif

endmodule

/* test/escaped_byte_stream_memory_loader_test.sv */
// Self-checking bench for the escaped byte stream memory loader: drives received bytes,
// predicts each write command item and compares it field by field.
// Depends on ebml_pkg, the ebml_byte_if / ebml_cmd_if interfaces and the loader RTL.
`timescale 1ns / 1ps

module escaped_byte_stream_memory_loader_test import ebml_pkg::*;;

  logic clk;
  logic rst;

  ebml_byte_if rx_ch ();
  ebml_cmd_if  wr_ch ();

  escaped_byte_stream_memory_loader dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch.sink),
    .wr  (wr_ch.source)
  );

  // Bytes waiting to be sent and command items waiting to be seen
  logic [7:0] rx_pending[$];
  result_t    cmd_expected[$];
  int         mismatch_count = 0;
  logic       calm = 1'b0;

  // Loader state as the bench tracks it
  mode_t                ld_mode   = MODE_IDLE;
  logic                 esc_armed = 1'b0;
  logic [2:0]           addr_left = 3'd0;
  logic [AddrWidth-1:0] load_addr = '0;
  logic [7:0]           led_now   = LedReset;
  result_t              predicted;

  always #4 clk = ~clk;

  // Keep inputs known before the first edge
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    wr_ch.ready = 1'b0;
  end

  // Advance the loader state by one byte and build the command item it yields
  task automatic decode_byte(input logic [7:0] b, output result_t r);
    logic [31:0] shifted;
    logic        is_data;
    r = '0;
    is_data = 1'b0;
    if (ld_mode == MODE_HALT) begin
      // halted: ignore everything
    end else if (addr_left != 3'd0 && addr_left <= AddrBytes) begin
      shifted = {24'h0, b} << (8 * (AddrBytes - addr_left));
      load_addr = load_addr | shifted[AddrWidth-1:0];
      addr_left = addr_left - 3'd1;
      if (addr_left == 3'd0) begin
        led_now = LedLoadReady;
        ld_mode = MODE_LOAD;
      end
    end else begin
      addr_left = 3'd0;
      if (esc_armed) begin
        esc_armed = 1'b0;
        is_data = 1'b1;
      end else begin
        led_now = LedBusy;
        if (b == ByteEscape) begin
          esc_armed = 1'b1;
        end else if (b == ByteLoad) begin
          load_addr = '0;
          led_now = LedLoadStart;
          addr_left = AddrBytes;
        end else if (b == ByteExit) begin
          led_now = LedExit;
          ld_mode = MODE_HALT;
          r.exit_now = 1'b1;
        end else begin
          is_data = 1'b1;
        end
      end
    end
    // Data bytes only land in memory while loading
    if (is_data && ld_mode == MODE_LOAD) begin
      r.write_valid = 1'b1;
      r.write_address = 32'(load_addr);
      r.write_data = b;
      led_now = b;
      load_addr = load_addr + 1'b1;
    end
    r.status_leds = led_now;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Driver: present the next byte, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        decode_byte(rx_ch.rx_byte, predicted);
        cmd_expected.push_back(predicted);
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= rx_pending.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each accepted command item
  always @(posedge clk) begin
    if (rst) begin
      wr_ch.ready <= 1'b0;
    end else begin
      if (wr_ch.valid && wr_ch.ready) begin
        if (cmd_expected.size() == 0) begin
          note_mismatch("unexpected item", 32'(wr_ch.write_address), 32'h0);
        end else begin
          predicted = cmd_expected.pop_front();
          if (wr_ch.write_valid !== predicted.write_valid)
            note_mismatch("write_valid", 32'(wr_ch.write_valid), 32'(predicted.write_valid));
          if (wr_ch.write_address !== predicted.write_address)
            note_mismatch("write_address", wr_ch.write_address, predicted.write_address);
          if (wr_ch.write_data !== predicted.write_data)
            note_mismatch("write_data", 32'(wr_ch.write_data), 32'(predicted.write_data));
          if (wr_ch.exit_now !== predicted.exit_now)
            note_mismatch("exit_now", 32'(wr_ch.exit_now), 32'(predicted.exit_now));
          if (wr_ch.status_leds !== predicted.status_leds)
            note_mismatch("status_leds", 32'(wr_ch.status_leds), 32'(predicted.status_leds));
        end
      end
      wr_ch.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Bias toward command codes and the byte extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[5];
    corner = '{ByteExit, ByteLoad, ByteEscape, 8'hff, 8'h80};
    if ($urandom_range(3) == 0) return corner[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  // Queue well-formed load / data sequences; every sequence ends where a
  // command may follow, and a raw exit byte is only ever produced here as an address byte
  task automatic queue_random_items(input int n);
    int         pushed;
    logic [7:0] b;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(99) < 12) begin
        rx_pending.push_back(ByteLoad);
        if ($urandom_range(3) == 0) begin
          // start near the top of the address space so that later data can wrap
          rx_pending.push_back(8'($urandom_range(255, 240)));
          repeat (3) rx_pending.push_back(8'hff);
        end else begin
          repeat (4) rx_pending.push_back(pick_byte());
        end
        pushed += 5;
      end else begin
        b = pick_byte();
        if (b == ByteExit || b == ByteLoad || b == ByteEscape || $urandom_range(9) == 0) begin
          rx_pending.push_back(ByteEscape);
          pushed++;
        end
        rx_pending.push_back(b);
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || rx_ch.valid || cmd_expected.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Idle mode: plain and escaped bytes are dropped
    rx_pending = '{8'h55, 8'hff, ByteEscape, ByteLoad};
    // Load with raw command codes inside the address
    rx_pending.push_back(ByteLoad);
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteExit);
    rx_pending.push_back(ByteLoad);
    rx_pending.push_back(8'hff);
    rx_pending.push_back(8'h80);
    // Escaped exit, escape and load are plain data
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteExit);
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteLoad);
    // Load while loading, at the top address, then wrap to zero
    rx_pending.push_back(ByteLoad);
    repeat (4) rx_pending.push_back(8'hff);
    rx_pending.push_back(8'ha5);
    rx_pending.push_back(8'h5a);
    wait_drained();

    queue_random_items(300);
    // Hold the sender until every command item is back
    wait_drained();

    calm = 1'b1;
    queue_random_items(150);
    wait_drained();
    calm = 1'b0;

    queue_random_items(400);
    // Exit, then bytes the halted loader must ignore
    rx_pending.push_back(ByteExit);
    rx_pending.push_back(ByteLoad);
    rx_pending.push_back(ByteEscape);
    rx_pending.push_back(ByteExit);
    rx_pending.push_back(8'h42);

    waited = 0;
    while ((rx_pending.size() != 0 || rx_ch.valid || cmd_expected.size() != 0)
           && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (cmd_expected.size() != 0)
      note_mismatch("items never seen", 32'(cmd_expected.size()), 32'h0);
    if (mismatch_count == 0) begin
      $display("escaped_byte_stream_memory_loader_test: clean");
    end else begin
      $display("escaped_byte_stream_memory_loader_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("escaped_byte_stream_memory_loader_test: errors");
    $finish;
  end

endmodule
